/* rtl/murmur64a_stream_hash_macros.svh */
// Assertion macros for the checker file of the hash block.
`ifndef MURMUR64A_STREAM_HASH_MACROS_SVH
`define MURMUR64A_STREAM_HASH_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define MSH_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error("hash block check failed");

// Consequent in the cycle after the antecedent.
`define MSH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error("hash block check failed");

`endif

/* rtl/mh64_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mh64_pkg;

  // Mixing multiplier, split into halves for the 32x32 multiplier
  localparam logic [63:0] MulM     = 64'hc6a4_a793_5bd1_e995;
  localparam logic [31:0] MulMLo   = MulM[31:0];
  localparam logic [31:0] MulMHi   = MulM[63:32];
  localparam int unsigned ShiftR   = 47;
  localparam logic [63:0] SeedReset = 64'd7576351903513440497;

  // Sequencer state encoding width
  localparam int unsigned StW = 3;

  // Next step chosen when a data word is applied
  typedef struct packed {
    logic [StW-1:0] state;
    logic [63:0]    op;
    logic [63:0]    h;
  } disp_t;

endpackage

`default_nettype wire

/* rtl/murmur64a_stream_hash.sv */
// 64-bit MurmurHash64A over a stream of little-endian 64-bit words.
// Input channel (in_valid_i / in_ready_o) carries one word per transfer with
// valid_bytes, first_item, last_item and message_length (read on first only).
// Output channel (out_valid_o / out_ready_i) gives one hash per last item.
// The seed register is written through seed_we_i / seed_i. The user must
// write it only while idle; the block itself does not enforce this.
// All 64-bit multiplies by the constant run on one shared 32x32 multiplier,
// each as low*low, then low*high, then high*low partial products.
// A full word runs the K1, K2 and H products, a tail word only the H
// product, and an empty word none (ready stays high); a first item adds
// the length product and a last item adds the avalanche.
// in_ready_o is high only while the sequencer is idle.
// The result sits in an output register; a new item is accepted while it
// waits. If the receiver stalls, a following avalanche holds in its last
// step until the register frees, so no result is lost.
// Reset clears the sequencer, the open-message flag and the output valid,
// and loads the seed with its default value.
`timescale 1ns / 1ps
`default_nettype none

module murmur64a_stream_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        seed_we_i,
  input  logic [63:0] seed_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] data_word_i,
  input  logic [3:0]  valid_bytes_i,
  input  logic        first_item_i,
  input  logic        last_item_i,
  input  logic [31:0] message_length_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] hash_value_o
);
  import mh64_pkg::*;

  localparam logic [StW-1:0] ST_IDLE = 3'd0;
  localparam logic [StW-1:0] ST_LEN  = 3'd1;
  localparam logic [StW-1:0] ST_K1   = 3'd2;
  localparam logic [StW-1:0] ST_K2   = 3'd3;
  localparam logic [StW-1:0] ST_H    = 3'd4;
  localparam logic [StW-1:0] ST_AV   = 3'd5;

  localparam logic [1:0] PH_FIRST = 2'd0;
  localparam logic [1:0] PH_MID   = 2'd1;
  localparam logic [1:0] PH_LAST  = 2'd2;

  logic [StW-1:0] state_q, state_d;
  logic [1:0]     phase_q, phase_d;
  logic [63:0]    acc_q, acc_d;
  logic [63:0]    op_q, op_d;
  logic [63:0]    h_q, h_d;
  logic [63:0]    word_q, word_d;
  logic [3:0]     nb_q, nb_d;
  logic           last_q, last_d;
  logic           in_msg_q, in_msg_d;
  logic [63:0]    seed_q;
  logic           out_valid_q, out_valid_d;
  logic [63:0]    hash_q, hash_d;

  logic [31:0]    mul_a, mul_b;
  logic [63:0]    pp, sum;
  logic           done, stall;
  disp_t          disp;

  // Apply one data word: full word, tail, or nothing (avalanche if last)
  function automatic disp_t dispatch(input logic [63:0] hcur, input logic [63:0] w,
                                     input logic [3:0] nb, input logic lst);
    disp_t       r;
    logic [63:0] mask;
    logic [63:0] ht;
    mask = ~(64'hFFFF_FFFF_FFFF_FFFF << {nb[2:0], 3'b000});
    ht   = hcur ^ (w & mask);
    r.h  = hcur;
    priority if (nb[3]) begin
      r.state = ST_K1;
      r.op    = w;
    end else if (nb[2:0] != 3'd0) begin
      r.state = ST_H;
      r.op    = ht;
      r.h     = ht;
    end else if (lst) begin
      r.state = ST_AV;
      r.op    = hcur ^ (hcur >> ShiftR);
    end else begin
      r.state = ST_IDLE;
      r.op    = hcur;
    end
    return r;
  endfunction

  // Shared 32x32 multiplier and partial-product accumulate
  assign mul_a = (phase_q == PH_LAST) ? op_q[63:32] : op_q[31:0];
  assign mul_b = (phase_q == PH_MID) ? MulMHi : MulMLo;
  assign pp    = 64'(mul_a) * 64'(mul_b);
  assign sum   = (phase_q == PH_FIRST) ? pp : acc_q + {pp[31:0], 32'h0};
  assign done  = (phase_q == PH_LAST);
  assign stall = (state_q == ST_AV) && done && out_valid_q && !out_ready_i;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    acc_d       = acc_q;
    op_d        = op_q;
    h_d         = h_q;
    word_d      = word_q;
    nb_d        = nb_q;
    last_d      = last_q;
    in_msg_d    = in_msg_q;
    out_valid_d = out_valid_q && !out_ready_i;
    hash_d      = hash_q;
    disp        = dispatch(h_q, word_q, nb_q, last_q);

    if (state_q != ST_IDLE && !stall) begin
      acc_d   = sum;
      phase_d = done ? PH_FIRST : phase_q + 2'd1;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          word_d = data_word_i;
          nb_d   = valid_bytes_i;
          last_d = last_item_i;
          if (first_item_i) begin
            state_d  = ST_LEN;
            op_d     = {32'h0, message_length_i};
            in_msg_d = 1'b1;
          end else if (in_msg_q) begin
            disp    = dispatch(h_q, data_word_i, valid_bytes_i, last_item_i);
            state_d = disp.state;
            op_d    = disp.op;
            h_d     = disp.h;
          end
        end
      end
      ST_LEN: begin
        if (done) begin
          disp    = dispatch(seed_q ^ sum, word_q, nb_q, last_q);
          state_d = disp.state;
          op_d    = disp.op;
          h_d     = disp.h;
        end
      end
      ST_K1: begin
        if (done) begin
          state_d = ST_K2;
          op_d    = sum ^ (sum >> ShiftR);
        end
      end
      ST_K2: begin
        if (done) begin
          state_d = ST_H;
          op_d    = h_q ^ sum;
          h_d     = h_q ^ sum;
        end
      end
      ST_H: begin
        if (done) begin
          h_d = sum;
          if (last_q) begin
            state_d = ST_AV;
            op_d    = sum ^ (sum >> ShiftR);
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_AV: begin
        if (done && !stall) begin
          state_d     = ST_IDLE;
          hash_d      = sum ^ (sum >> ShiftR);
          out_valid_d = 1'b1;
          in_msg_d    = 1'b0;
        end
      end
      default: begin
        state_d = ST_IDLE;
        phase_d = PH_FIRST;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_FIRST;
      in_msg_q    <= 1'b0;
      out_valid_q <= 1'b0;
      h_q         <= 64'h0;
      seed_q      <= SeedReset;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      in_msg_q    <= in_msg_d;
      out_valid_q <= out_valid_d;
      h_q         <= h_d;
      if (seed_we_i) begin
        seed_q <= seed_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    op_q   <= op_d;
    word_q <= word_d;
    nb_q   <= nb_d;
    last_q <= last_d;
    hash_q <= hash_d;
  end

  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign hash_value_o = hash_q;

endmodule

`default_nettype wire

/* rtl/mh64_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "murmur64a_stream_hash_macros.svh"

module mh64_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        first_item_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] hash_value_o
);

  // A stalled result stays offered and unchanged
  `MSH_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(hash_value_o))

  // A message start always runs the length product, so the block goes busy
  `MSH_ASSERT_NEXT(a_first_busy, in_valid_i && in_ready_o && first_item_i, !in_ready_o)

  // A new result only comes out of the avalanche, never straight from idle
  `MSH_ASSERT_SAME(a_out_from_busy, $rose(out_valid_o), !$past(in_ready_o))

  // Result valid never rises while the receiver is still holding the old one
  `MSH_ASSERT_NEXT(a_no_overwrite, out_valid_o && !out_ready_i, !$rose(out_valid_o))

endmodule

bind murmur64a_stream_hash mh64_checker u_mh64_checker (.*);

`default_nettype wire
